// ===== rtl/gbrd_pkg.sv =====
package gbrd_pkg;

  // Board storage
  localparam int GRID_MAX    = 32;
  localparam int COORD_W     = $clog2(GRID_MAX);
  localparam int SIZE_W      = 6;
  localparam int CELLS       = GRID_MAX * GRID_MAX;
  localparam int QUEUE_DEPTH = CELLS + 1;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int DIST_W      = 10;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(GRID_MAX);

  // Request opcodes
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_MARK  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  // Neighbor directions, in expansion order
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_LEFT  = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [4:0] row;
    logic [4:0] col;
    logic [4:0] target_row;
  } gbrd_in_t;

  typedef struct packed {
    logic [9:0] distance;
    logic       reachable;
  } gbrd_out_t;

  typedef struct packed {
    logic [COORD_W-1:0] r;
    logic [COORD_W-1:0] c;
    logic [DIST_W-1:0]  len;
  } gbrd_qent_t;

  // Controller to datapath
  typedef struct packed {
    logic       clr_block;
    logic       mark_block;
    logic       start_query;
    logic       q_rd;
    logic       pop_adv;
    logic       nb_rd;
    logic [1:0] nb_dir;
    logic       nb_eval;
    logic       res_found;
    logic       res_none;
  } gbrd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic q_empty;
    logic hit;
  } gbrd_stat_t;

endpackage

// ===== rtl/gbrd_datapath.sv =====
module gbrd_datapath
  import gbrd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  gbrd_in_t          in_data,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_wdata,
  input  gbrd_cmd_t         cmd,
  output gbrd_stat_t        stat,
  output gbrd_out_t         out_data
);

  localparam logic [GRID_MAX-1:0] BIT_LSB = GRID_MAX'(1);
  localparam logic [SIZE_W:0]     GRID_LIM = (SIZE_W+1)'(GRID_MAX);

  // Board size register
  logic [SIZE_W-1:0] board_size_r;
  logic [SIZE_W:0]   n_eff;

  // Row-organized maps with per-row valid bits
  logic [GRID_MAX-1:0] blk_mem [GRID_MAX];
  logic [GRID_MAX-1:0] vis_mem [GRID_MAX];
  logic [GRID_MAX-1:0] blk_vld_r;
  logic [GRID_MAX-1:0] vis_vld_r;

  // Frontier queue
  gbrd_qent_t        q_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] head_r;
  logic [QPTR_W-1:0] tail_r;
  gbrd_qent_t        q_data_r;
  logic [COORD_W-1:0] target_r;

  // Neighbor under test
  logic [SIZE_W-1:0]   nr6, nc6;
  logic                nb_inb;
  logic [COORD_W-1:0]  nr_r, nc_r;
  logic                inb_r;
  logic [GRID_MAX-1:0] blk_row_r, vis_row_r;
  logic                blk_v_r, vis_v_r;
  logic                nb_blocked, nb_seen, take;
  logic [DIST_W-1:0]   len_nxt;
  logic                q_room;

  gbrd_out_t out_data_r;

  assign n_eff = ({1'b0, board_size_r} > GRID_LIM) ? GRID_LIM : {1'b0, board_size_r};

  always_comb begin
    nr6 = {1'b0, q_data_r.r};
    nc6 = {1'b0, q_data_r.c};
    unique case (cmd.nb_dir)
      DIR_UP:    nr6 = {1'b0, q_data_r.r} - 1'b1;
      DIR_RIGHT: nc6 = {1'b0, q_data_r.c} + 1'b1;
      DIR_DOWN:  nr6 = {1'b0, q_data_r.r} + 1'b1;
      DIR_LEFT:  nc6 = {1'b0, q_data_r.c} - 1'b1;
      default:   nr6 = {1'b0, q_data_r.r};
    endcase
    // a wrap below zero lands at the top of the 6-bit range, past any board
    nb_inb = ({1'b0, nr6} < n_eff) && ({1'b0, nc6} < n_eff);
  end

  assign nb_blocked = blk_v_r & blk_row_r[nc_r];
  assign nb_seen    = vis_v_r & vis_row_r[nc_r];
  assign take       = cmd.nb_eval & inb_r & ~nb_blocked & ~nb_seen;
  assign len_nxt    = (q_data_r.len == DIST_MAX) ? DIST_MAX : q_data_r.len + 1'b1;
  assign q_room     = ({1'b0, tail_r} < (QPTR_W+1)'(QUEUE_DEPTH));

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      board_size_r <= SIZE_RESET;
      blk_vld_r    <= '0;
      vis_vld_r    <= '0;
      head_r       <= '0;
      tail_r       <= '0;
    end else begin
      if (cfg_we) begin
        board_size_r <= cfg_wdata;
      end
      if (cmd.clr_block) begin
        blk_vld_r <= '0;
      end else if (cmd.mark_block) begin
        blk_vld_r[in_data.row] <= 1'b1;
      end
      if (cmd.start_query) begin
        vis_vld_r <= '0;
        head_r    <= '0;
        tail_r    <= QPTR_W'(1);
      end else begin
        if (take) begin
          vis_vld_r[nr_r] <= 1'b1;
          if (q_room) begin
            tail_r <= tail_r + 1'b1;
          end
        end
        if (cmd.pop_adv) begin
          head_r <= head_r + 1'b1;
        end
      end
    end
  end

  // Memories and payload
  always_ff @(posedge clk) begin
    if (cmd.mark_block) begin
      if (blk_vld_r[in_data.row]) begin
        blk_mem[in_data.row][in_data.col] <= 1'b1;
      end else begin
        blk_mem[in_data.row] <= BIT_LSB << in_data.col;
      end
    end
    if (take) begin
      if (vis_vld_r[nr_r]) begin
        vis_mem[nr_r][nc_r] <= 1'b1;
      end else begin
        vis_mem[nr_r] <= BIT_LSB << nc_r;
      end
    end
    if (cmd.start_query) begin
      q_mem[0] <= '{r: in_data.row, c: in_data.col, len: '0};
      target_r <= in_data.target_row;
    end else if (take && q_room) begin
      q_mem[tail_r] <= '{r: nr_r, c: nc_r, len: len_nxt};
    end
    if (cmd.q_rd) begin
      q_data_r <= q_mem[head_r];
    end
    if (cmd.nb_rd) begin
      nr_r      <= nr6[COORD_W-1:0];
      nc_r      <= nc6[COORD_W-1:0];
      inb_r     <= nb_inb;
      blk_row_r <= blk_mem[nr6[COORD_W-1:0]];
      vis_row_r <= vis_mem[nr6[COORD_W-1:0]];
      blk_v_r   <= blk_vld_r[nr6[COORD_W-1:0]];
      vis_v_r   <= vis_vld_r[nr6[COORD_W-1:0]];
    end
    if (cmd.res_found) begin
      out_data_r <= '{distance: q_data_r.len, reachable: 1'b1};
    end else if (cmd.res_none) begin
      out_data_r <= '{distance: '0, reachable: 1'b0};
    end
  end

  assign stat.q_empty = (head_r == tail_r);
  assign stat.hit     = (q_data_r.r == target_r);
  assign out_data     = out_data_r;

`ifndef NO_ASSERTIONS
  a_head_le_tail: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= tail_r) else $error("queue head passed tail");
  a_tail_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, tail_r} <= (QPTR_W+1)'(QUEUE_DEPTH)) else $error("queue tail out of range");
  a_query_init: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start_query |=> (head_r == '0) && (tail_r == QPTR_W'(1)))
    else $error("queue not seeded on query start");
`endif

endmodule

// ===== rtl/gbrd_ctrl.sv =====
module gbrd_ctrl
  import gbrd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] op,
  input  gbrd_stat_t stat,
  output gbrd_cmd_t  cmd,
  output logic       busy,
  output logic       out_valid
);

  typedef enum logic [1:0] {S_IDLE, S_POP, S_CHECK, S_EXPAND} state_t;

  state_t     state_r, state_nxt;
  logic [2:0] k_r, k_nxt;
  logic       out_valid_r, out_valid_nxt;

  localparam logic [2:0] K_DONE = 3'd4;

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    out_valid_nxt = 1'b0;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (op)
            OP_CLEAR: cmd.clr_block = 1'b1;
            OP_MARK:  cmd.mark_block = 1'b1;
            OP_QUERY: begin
              cmd.start_query = 1'b1;
              state_nxt       = S_POP;
            end
            default: ;
          endcase
        end
      end
      S_POP: begin
        if (stat.q_empty) begin
          cmd.res_none  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cmd.q_rd  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.hit) begin
          cmd.res_found = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cmd.pop_adv = 1'b1;
          cmd.nb_rd   = 1'b1;
          cmd.nb_dir  = DIR_UP;
          k_nxt       = 3'd1;
          state_nxt   = S_EXPAND;
        end
      end
      S_EXPAND: begin
        // read neighbor k while testing neighbor k-1
        cmd.nb_eval = 1'b1;
        if (k_r == K_DONE) begin
          state_nxt = S_POP;
        end else begin
          cmd.nb_rd  = 1'b1;
          cmd.nb_dir = k_r[1:0];
          k_nxt      = k_r + 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

`ifndef NO_ASSERTIONS
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r) else $error("result strobe longer than one cycle");
  a_query_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && start && op == OP_QUERY) |=> (state_r == S_POP))
    else $error("query not started");
  a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
    k_r <= K_DONE) else $error("neighbor counter out of range");
`endif

endmodule

// ===== rtl/grid_bfs_row_distance_unit.sv =====
// Grid breadth-first search: shortest four-neighbor path to a target row.
//
// Request channel: drive in_data and pulse start; the request is taken on a
// rising edge where start is high and busy is low. Opcodes: clear the map,
// mark one cell blocked, or query the distance from (row, col) to target_row.
// Clear and mark finish in the cycle they are taken; busy stays low and no
// result is produced. A query raises busy until its result is out.
// Result channel: out_valid is high for exactly one cycle with out_data; the
// receiver cannot stall it, so sample it on that edge. busy drops together
// with the result strobe, so the next request may be taken in that cycle.
// A query takes a queue read and a target check for each dequeued cell;
// a cell that is expanded then has its four neighbors read and tested, one
// neighbor read and test per cycle, pipelined. The single-port frontier
// queue memory and the row-wide blocked/visited maps set this pace.
// cfg_we/cfg_wdata write board_size; write only while idle.
// Reset: board_size returns to 32 and the blocked map reads as all clear at
// once through per-row valid bits, so no clearing pass is needed.
module grid_bfs_row_distance_unit
  import gbrd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  gbrd_in_t          in_data,
  output logic              out_valid,
  output gbrd_out_t         out_data,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_wdata
);

  gbrd_cmd_t  cmd;
  gbrd_stat_t stat;

  // Sequencer: decodes requests and steps the search
  gbrd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .op        (in_data.op),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // Maps, frontier queue, neighbor test and result register
  gbrd_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule
